// ----- src/mbe_pkg.sv -----
// shared types, constants and arithmetic helpers for the mandelbrot escape-time unit
// no dependencies
package mbe_pkg;

  localparam int LANES      = 4;
  localparam int FRAC_BITS  = 28;
  localparam int ITER_LIMIT = 256;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int LCOL_W     = 11;  // column plus lane offset
  localparam int CNT_W      = 9;
  localparam int STEP_W     = 31;
  localparam int RGB_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE    = 3'd0,
    REG_ORIGIN_IM    = 3'd1,
    REG_STEP_RE      = 3'd2,
    REG_STEP_IM      = 3'd3,
    REG_MAX_ITER     = 3'd4,
    REG_ESCAPE_LIMIT = 3'd5
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic c_mul;     // form column and row products
    logic c_add;     // form c, load z
    logic z_mul;     // form squares and cross product
    logic z_upd;     // update z, escape flag, count
    logic out_load;  // capture result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic all_done;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(sqrt(v)) one result bit per step
  function automatic logic [4:0] isqrt9(input logic [CNT_W-1:0] v);
    logic [4:0] root;
    logic [4:0] cand;
    root = '0;
    for (int b = 4; b >= 0; b--) begin
      cand = root | (5'd1 << b);
      if ((10'(cand) * 10'(cand)) <= 10'(v)) begin
        root = cand;
      end
    end
    return root;
  endfunction

endpackage

// ----- src/mandelbrot_escape_time_4lane_unit.sv -----
// mandelbrot escape-time unit, four adjacent pixels per transfer
// depends on mbe_pkg, mbe_ctrl, mbe_lane
// sequence: start transfer, column and row products, c and z load, then n iterations, where n is the
//   number of iterations run (n <= min(max_iter, 256), fewer once all lanes escape), then the done strobe
// one group at a time: each iteration is a multiply state and an update state in the four lanes;
//   the next start can be taken in the cycle done is high
// reset: synchronous, configuration registers return to their documented defaults, controller idles
// done marks the result for one cycle; the receiver cannot stall
module mandelbrot_escape_time_4lane_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data,
  // command side
  input  logic                           start,
  input  logic [mbe_pkg::COL_W-1:0]      start_column,
  input  logic [mbe_pkg::ROW_W-1:0]      pixel_row,
  output logic                           busy,
  // result side
  output logic                           done,
  output logic [mbe_pkg::CNT_W-1:0]      count_lane0,
  output logic [mbe_pkg::CNT_W-1:0]      count_lane1,
  output logic [mbe_pkg::CNT_W-1:0]      count_lane2,
  output logic [mbe_pkg::CNT_W-1:0]      count_lane3,
  output logic [mbe_pkg::RGB_W-1:0]      rgb_lane0,
  output logic [mbe_pkg::RGB_W-1:0]      rgb_lane1,
  output logic [mbe_pkg::RGB_W-1:0]      rgb_lane2,
  output logic [mbe_pkg::RGB_W-1:0]      rgb_lane3
);
  import mbe_pkg::*;

  // configuration registers
  logic signed [31:0]  origin_re, origin_im;
  logic [STEP_W-1:0]   step_re, step_im, escape_limit;
  logic [8:0]          max_iter;
  logic [8:0]          limit;

  // captured item
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;

  cmd_t                cmd;
  status_t             status;
  logic [LANES-1:0]    lane_done;
  logic [CNT_W-1:0]    lane_count [LANES];
  logic [CNT_W-1:0]    res_count  [LANES];
  logic [RGB_W-1:0]    res_rgb    [LANES];

  // register writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re    <= -32'sd456340275;
      origin_im    <= -32'sd241591910;
      step_re      <= 31'd738198;
      step_im      <= 31'd934155;
      max_iter     <= 9'd256;
      escape_limit <= 31'd1342177280;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_RE:    origin_re    <= cfg_data;
        REG_ORIGIN_IM:    origin_im    <= cfg_data;
        REG_STEP_RE:      step_re      <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:      step_im      <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:     max_iter     <= cfg_data[8:0];
        REG_ESCAPE_LIMIT: escape_limit <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // cap iteration count at the design limit
  assign limit = (max_iter > 9'(ITER_LIMIT)) ? 9'(ITER_LIMIT) : max_iter;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= start_column;
      row_q <= pixel_row;
    end
  end

  mbe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .limit  (limit),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // lane k sits at column start_column + k, same row for all
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mbe_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .col          (LCOL_W'(col_q) + LCOL_W'(k)),
      .row          (row_q),
      .origin_re    (origin_re),
      .origin_im    (origin_im),
      .step_re      (step_re),
      .step_im      (step_im),
      .escape_limit (escape_limit),
      .done         (lane_done[k]),
      .count        (lane_count[k])
    );
  end

  // iteration stops early once every lane has escaped
  assign status.all_done = &lane_done;

  // result registers; colors formed from the frozen counts
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < LANES; k++) begin
        res_count[k] <= lane_count[k];
        res_rgb[k]   <= {lane_count[k][4:0], 3'b000,
                         lane_count[k][6:0], 1'b0,
                         3'b000, isqrt9(lane_count[k])};
      end
    end
  end

  // one-cycle strobe after the capture
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_load;
    end
  end

  assign count_lane0 = res_count[0];
  assign count_lane1 = res_count[1];
  assign count_lane2 = res_count[2];
  assign count_lane3 = res_count[3];
  assign rgb_lane0   = res_rgb[0];
  assign rgb_lane1   = res_rgb[1];
  assign rgb_lane2   = res_rgb[2];
  assign rgb_lane3   = res_rgb[3];

endmodule

// ----- src/mbe_ctrl.sv -----
// sequencing state machine of the mandelbrot escape-time unit
// depends on mbe_pkg
module mbe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [8:0]            limit,
  input  mbe_pkg::status_t      status,
  output mbe_pkg::cmd_t         cmd,
  output logic                  busy
);
  import mbe_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMUL = 6'b000010,
    S_CADD = 6'b000100,
    S_MUL  = 6'b001000,
    S_UPD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [8:0] iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd.c_mul  = 1'b1;
        state_next = S_CADD;
      end
      S_CADD: begin
        cmd.c_add  = 1'b1;
        iter_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (status.all_done || iter == limit) begin
          state_next = S_FIN;
        end else begin
          cmd.z_mul  = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.z_upd  = 1'b1;
        iter_next  = iter + 9'd1;
        state_next = S_MUL;
      end
      S_FIN: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- src/mbe_lane.sv -----
// one pixel lane: point mapping, z iteration, escape flag and count
// depends on mbe_pkg
module mbe_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  mbe_pkg::cmd_t                 cmd,
  input  logic [mbe_pkg::LCOL_W-1:0]    col,
  input  logic [mbe_pkg::ROW_W-1:0]     row,
  input  logic signed [31:0]            origin_re,
  input  logic signed [31:0]            origin_im,
  input  logic [mbe_pkg::STEP_W-1:0]    step_re,
  input  logic [mbe_pkg::STEP_W-1:0]    step_im,
  input  logic [mbe_pkg::STEP_W-1:0]    escape_limit,
  output logic                          done,
  output logic [mbe_pkg::CNT_W-1:0]     count
);
  import mbe_pkg::*;

  localparam int PRE_RE_W = LCOL_W + STEP_W;
  localparam int PRE_IM_W = ROW_W + STEP_W;

  logic [PRE_RE_W-1:0] pre_re;
  logic [PRE_IM_W-1:0] pre_im;
  logic signed [31:0]  cx, cy, zx, zy;
  logic signed [63:0]  pxx, pyy, pxy;

  logic signed [31:0]  x2, y2, xy, r2, zx_next, zy_next;
  logic                esc, done_next;

  always_comb begin
    x2        = sat32(pxx >>> FRAC_BITS);
    y2        = sat32(pyy >>> FRAC_BITS);
    xy        = sat32(pxy >>> FRAC_BITS);
    r2        = sat32(64'(x2) + 64'(y2));
    esc       = r2 > $signed({1'b0, escape_limit});
    done_next = done | esc;
    zx_next   = sat32(64'(x2) - 64'(y2) + 64'(cx));
    zy_next   = sat32((64'(xy) <<< 1) + 64'(cy));
  end

  always_ff @(posedge clk) begin
    if (cmd.c_mul) begin
      pre_re <= PRE_RE_W'(col) * PRE_RE_W'(step_re);
      pre_im <= PRE_IM_W'(row) * PRE_IM_W'(step_im);
    end
    if (cmd.c_add) begin
      cx <= sat32(64'(origin_re) + $signed(64'(pre_re)));
      cy <= sat32(64'(origin_im) + $signed(64'(pre_im)));
      zx <= sat32(64'(origin_re) + $signed(64'(pre_re)));
      zy <= sat32(64'(origin_im) + $signed(64'(pre_im)));
    end
    if (cmd.z_mul) begin
      pxx <= 64'(zx) * 64'(zx);
      pyy <= 64'(zy) * 64'(zy);
      pxy <= 64'(zx) * 64'(zy);
    end
    if (cmd.z_upd) begin
      zx <= zx_next;
      zy <= zy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end else if (cmd.c_add) begin
      done  <= 1'b0;
      count <= '0;
    end else if (cmd.z_upd) begin
      done <= done_next;
      if (!done_next) begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule

// ----- sim/tb_mandelbrot_escape_time_4lane_unit.sv -----
// self-checking testbench for mandelbrot_escape_time_4lane_unit: random and directed pixel groups
// under many register settings, checked against an in-bench fixed-point escape-time predictor
// depends on mbe_pkg and the unit under test
module tb_mandelbrot_escape_time_4lane_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  // register indexes the unit does not decode, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // one pixel group as sent on the command side
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } group_t;

  // per-lane counts and colors of one group
  typedef struct packed {
    logic [LANES-1:0][CNT_W-1:0] cnt;
    logic [LANES-1:0][RGB_W-1:0] rgb;
  } lane_colors_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  start        = 1'b0;
  logic [COL_W-1:0]      start_column = '0;
  logic [ROW_W-1:0]      pixel_row    = '0;
  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      count_lane0, count_lane1, count_lane2, count_lane3;
  logic [RGB_W-1:0]      rgb_lane0, rgb_lane1, rgb_lane2, rgb_lane3;

  mandelbrot_escape_time_4lane_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .start_column (start_column),
    .pixel_row    (pixel_row),
    .busy         (busy),
    .done         (done),
    .count_lane0  (count_lane0),
    .count_lane1  (count_lane1),
    .count_lane2  (count_lane2),
    .count_lane3  (count_lane3),
    .rgb_lane0    (rgb_lane0),
    .rgb_lane1    (rgb_lane1),
    .rgb_lane2    (rgb_lane2),
    .rgb_lane3    (rgb_lane3)
  );

  always #6 clk = ~clk;

  // shadow copy of the register file, starts at the documented reset values
  int                cur_origin_re    = -456340275;
  int                cur_origin_im    = -241591910;
  logic [STEP_W-1:0] cur_step_re      = 31'd738198;
  logic [STEP_W-1:0] cur_step_im      = 31'd934155;
  logic [CNT_W-1:0]  cur_max_iter     = 9'd256;
  logic [STEP_W-1:0] cur_escape_limit = 31'd1342177280;

  group_t       pending_groups[$];    // groups waiting for the driver
  lane_colors_t expected_colors[$];   // predictions of accepted groups, oldest first

  int  idle_pct        = 0;           // chance in percent that the driver skips a cycle
  logic start_taken    = 1'b0;        // start transfer happened at the last rising edge
  int  errors          = 0;
  int  groups_sent     = 0;
  int  results_checked = 0;
  int  reg_settings    = 1;

  // clamp to the signed 32-bit range
  function automatic longint clip_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // fixed-point product, floor after the shift, then saturate
  function automatic longint qmul(input longint a, input longint b);
    return clip_s32((a * b) >>> FRAC_BITS);
  endfunction

  // escape-time counts and colors of the four pixels of one group
  function automatic lane_colors_t escape_counts(input logic [COL_W-1:0] col0,
                                                 input logic [ROW_W-1:0] row);
    lane_colors_t res;
    longint       cx[LANES];
    longint       cy[LANES];
    longint       zx[LANES];
    longint       zy[LANES];
    int unsigned  cnt[LANES];
    bit           gone[LANES];
    int unsigned  limit;
    int unsigned  iter;
    int unsigned  root;
    int           n_gone;
    longint       x2, y2, xy, r2;
    limit = (cur_max_iter > ITER_LIMIT) ? ITER_LIMIT : int'(cur_max_iter);
    for (int i = 0; i < LANES; i++) begin
      cx[i] = clip_s32(longint'(cur_origin_re) + longint'(int'(col0) + i) * longint'(cur_step_re));
      cy[i] = clip_s32(longint'(cur_origin_im) + longint'(int'(row)) * longint'(cur_step_im));
      zx[i] = cx[i];
      zy[i] = cy[i];
      cnt[i] = 0;
      gone[i] = 1'b0;
    end
    iter = 0;
    n_gone = 0;
    while (n_gone < LANES && iter < limit) begin
      n_gone = 0;
      for (int i = 0; i < LANES; i++) begin
        x2 = qmul(zx[i], zx[i]);
        y2 = qmul(zy[i], zy[i]);
        xy = qmul(zx[i], zy[i]);
        r2 = clip_s32(x2 + y2);
        if (r2 > longint'(cur_escape_limit)) gone[i] = 1'b1;
        zx[i] = clip_s32(x2 - y2 + cx[i]);
        zy[i] = clip_s32(2 * xy + cy[i]);
        if (!gone[i]) cnt[i]++;
        else n_gone++;
      end
      iter++;
    end
    for (int i = 0; i < LANES; i++) begin
      root = 0;
      while ((root + 1) * (root + 1) <= cnt[i]) root++;
      res.cnt[i] = cnt[i][CNT_W-1:0];
      res.rgb[i] = {8'(cnt[i] * 8), 8'(cnt[i] * 2), 8'(root)};
    end
    return res;
  endfunction

  // driver: offers the next pending group at the falling edge, holds it until transferred
  always @(negedge clk) begin
    group_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || start_taken) begin
      if (pending_groups.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_groups.pop_front();
        start <= 1'b1;
        start_column <= nxt.col;
        pixel_row <= nxt.row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks the done strobe first, then records a start transfer of the same edge
  always @(posedge clk) begin
    lane_colors_t             want;
    logic [LANES-1:0][CNT_W-1:0] got_cnt;
    logic [LANES-1:0][RGB_W-1:0] got_rgb;
    got_cnt = {count_lane3, count_lane2, count_lane1, count_lane0};
    got_rgb = {rgb_lane3, rgb_lane2, rgb_lane1, rgb_lane0};
    if (rst) begin
      start_taken <= 1'b0;
    end else begin
      start_taken <= start && !busy;
      if (done) begin
        if (expected_colors.size() == 0) begin
          $error("result strobe with no group outstanding");
          errors++;
        end else begin
          want = expected_colors.pop_front();
          results_checked++;
          for (int i = 0; i < LANES; i++) begin
            if (got_cnt[i] !== want.cnt[i]) begin
              $error("count_lane%0d: expected %0d, got %0d", i, want.cnt[i], got_cnt[i]);
              errors++;
            end
            if (got_rgb[i] !== want.rgb[i]) begin
              $error("rgb_lane%0d: expected %06h, got %06h", i, want.rgb[i], got_rgb[i]);
              errors++;
            end
          end
        end
      end
      if (start && !busy) begin
        expected_colors.push_back(escape_counts(start_column, pixel_row));
        groups_sent++;
      end
    end
  end

  // one register write, shadow copy follows; spare indexes leave it alone
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ORIGIN_RE:    cur_origin_re = int'(val);
      REG_ORIGIN_IM:    cur_origin_im = int'(val);
      REG_STEP_RE:      cur_step_re = val[STEP_W-1:0];
      REG_STEP_IM:      cur_step_im = val[STEP_W-1:0];
      REG_MAX_ITER:     cur_max_iter = val[CNT_W-1:0];
      REG_ESCAPE_LIMIT: cur_escape_limit = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  // max_iter with junk in the unused upper data bits
  task automatic write_max_iter(input int unsigned n);
    write_reg(REG_MAX_ITER, {23'($urandom), 9'(n)});
  endtask

  // wait until every transfer is done and every result has come back
  task automatic drain();
    while (pending_groups.size() != 0 || start || expected_colors.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_group(input int unsigned col, input int unsigned row);
    group_t g;
    g.col = COL_W'(col);
    g.row = ROW_W'(row);
    pending_groups.push_back(g);
  endtask

  // mostly aligned groups inside the image, some anywhere in the field range
  task automatic queue_random_groups(input int n);
    int unsigned col;
    int unsigned row;
    for (int k = 0; k < n; k++) begin
      col = ($urandom_range(9) < 7) ? $urandom_range(199) * 4 : $urandom_range(1023);
      row = ($urandom_range(4) != 0) ? $urandom_range(499) : $urandom_range(511);
      queue_group(col, row);
    end
  endtask

  // new random setting of all registers, extremes now and then; iteration cap kept small
  task automatic load_random_regs(input int unsigned iter_cap);
    case ($urandom_range(3))
      0:       write_reg(REG_ORIGIN_RE, 32'h8000_0000);
      1:       write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
      default: write_reg(REG_ORIGIN_RE, $urandom_range(939524096) - 671088640);
    endcase
    case ($urandom_range(3))
      0:       write_reg(REG_ORIGIN_IM, 32'h8000_0000);
      1:       write_reg(REG_ORIGIN_IM, 32'h7FFF_FFFF);
      default: write_reg(REG_ORIGIN_IM, $urandom_range(644245094) - 322122547);
    endcase
    case ($urandom_range(4))
      0:       write_reg(REG_STEP_RE, 32'h0000_0000);
      1:       write_reg(REG_STEP_RE, 32'hFFFF_FFFF);
      2:       write_reg(REG_STEP_RE, $urandom);
      default: write_reg(REG_STEP_RE, $urandom_range(2097152));
    endcase
    case ($urandom_range(4))
      0:       write_reg(REG_STEP_IM, 32'h0000_0000);
      1:       write_reg(REG_STEP_IM, 32'hFFFF_FFFF);
      2:       write_reg(REG_STEP_IM, $urandom);
      default: write_reg(REG_STEP_IM, $urandom_range(2097152));
    endcase
    case ($urandom_range(4))
      0:       write_reg(REG_ESCAPE_LIMIT, 32'h0000_0000);
      1:       write_reg(REG_ESCAPE_LIMIT, 32'hFFFF_FFFF);
      2:       write_reg(REG_ESCAPE_LIMIT, $urandom);
      default: write_reg(REG_ESCAPE_LIMIT, $urandom_range(1342177280, 268435456));
    endcase
    write_max_iter((iter_cap <= 1) ? 1 : $urandom_range(iter_cap, 1));
    // spare indexes must not disturb anything
    write_reg(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    reg_settings++;
  endtask

  // hard stop in case the unit hangs
  initial begin
    #36_000_000;
    $display("[mandelbrot_escape_time_4lane_unit] ERROR");
    $finish;
  end

  initial begin
    // reset held from time zero, released at a falling edge
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // first stretch: sender idles about a third of the time
    idle_pct = 35;

    // directed groups at reset settings: field extremes, image corners, unaligned columns
    queue_group(0, 0);
    queue_group(1023, 511);
    queue_group(799, 499);
    queue_group(796, 499);
    queue_group(0, 511);
    queue_group(1020, 0);
    queue_group(3, 250);
    queue_group(401, 250);
    queue_group(400, 250);
    queue_group(512, 256);
    queue_group(2, 1);
    queue_group(1, 0);
    queue_group(640, 100);
    queue_group(200, 400);
    queue_group(798, 300);
    queue_group(341, 170);
    queue_group(682, 341);
    queue_group(555, 77);
    queue_random_groups(150);
    drain();

    // zero iteration cap: every count must come back zero
    write_max_iter(0);
    write_reg(REG_SPARE_6, $urandom);
    reg_settings++;
    queue_random_groups(40);
    drain();

    // caps above the iteration limit, on a zoomed-in window so counts spread out
    write_reg(REG_STEP_RE, $urandom_range(200000, 1000));
    write_reg(REG_STEP_IM, $urandom_range(200000, 1000));
    write_max_iter(257);
    reg_settings++;
    queue_random_groups(40);
    drain();
    write_max_iter(511);
    reg_settings++;
    queue_random_groups(60);
    drain();

    // second stretch: sender idles about half the time, many random settings
    idle_pct = 53;
    for (int k = 0; k < 12; k++) begin
      load_random_regs((k == 0) ? 1 : 48);
      queue_random_groups(100);
      drain();
    end

    // last stretch: sender never idles
    idle_pct = 0;
    for (int k = 0; k < 6; k++) begin
      load_random_regs(48);
      queue_random_groups(80);
      drain();
    end

    // let any stray strobe show up before judging
    repeat (600) @(posedge clk);

    $display("checked %0d of %0d pixel groups over %0d register settings",
             results_checked, groups_sent, reg_settings);
    $display("covered iteration caps 0, 1, 256, 257, 511 and saturating windows and limits");
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("[mandelbrot_escape_time_4lane_unit] OK");
    end else begin
      if (expected_colors.size() != 0)
        $error("%0d pixel groups never returned a result", expected_colors.size());
      $display("[mandelbrot_escape_time_4lane_unit] ERROR");
    end
    $finish;
  end

endmodule
